// ===== sv/amh_pkg.sv =====
// ----------------------------------------------------------------------------
// amh_pkg
// Shared widths, codes and controller states of the addressable min-heap.
// ----------------------------------------------------------------------------
package amh_pkg;

  localparam int DEF_HEAP_DEPTH    = 256;
  localparam int DEF_ID_COUNT      = 256;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  localparam int ID_W   = 8;
  localparam int KEY_W  = 32;
  localparam int CAP_W  = 9;
  localparam int STAT_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_SET_KEY,
    OP_DEL_MIN,
    OP_REMOVE
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK,
    STS_FULL,
    STS_EXISTS,
    STS_EMPTY,
    STS_NO_ID
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_LAST,
    ST_RD_TGT,
    ST_GET_TGT,
    ST_SINK_RD,
    ST_SINK_L,
    ST_SINK_R,
    ST_SINK_MV,
    ST_RISE_RD,
    ST_RISE_MV,
    ST_PLACE,
    ST_FINISH
  } state_t;

endpackage

// ===== sv/amh_if.sv =====
// ----------------------------------------------------------------------------
// amh_if
// Request, response and configuration channels of the addressable min-heap.
// ----------------------------------------------------------------------------
interface amh_req_if #(parameter int PAYLOAD_WIDTH = amh_pkg::DEF_PAYLOAD_WIDTH);
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [amh_pkg::ID_W-1:0]         entry_id;
  logic signed [amh_pkg::KEY_W-1:0] entry_key;
  logic [PAYLOAD_WIDTH-1:0]         entry_payload;

  modport source (output valid, opcode, entry_id, entry_key, entry_payload, input ready);
  modport sink   (input valid, opcode, entry_id, entry_key, entry_payload, output ready);
endinterface

interface amh_rsp_if #(parameter int PAYLOAD_WIDTH = amh_pkg::DEF_PAYLOAD_WIDTH);
  logic                             valid;
  logic                             ready;
  logic [amh_pkg::STAT_W-1:0]       status;
  logic [amh_pkg::ID_W-1:0]         out_id;
  logic signed [amh_pkg::KEY_W-1:0] out_key;
  logic [PAYLOAD_WIDTH-1:0]         out_payload;

  modport source (output valid, status, out_id, out_key, out_payload, input ready);
  modport sink   (input valid, status, out_id, out_key, out_payload, output ready);
endinterface

interface amh_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [amh_pkg::CAP_W-1:0] capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

// ===== sv/addressable_min_heap.sv =====
// ----------------------------------------------------------------------------
// addressable_min_heap
// Indexed binary min-heap: insert, set key, delete minimum, remove by id.
// A rejected request goes straight to the response; an insert rises level by
// level; an extraction sinks level by level (one read fewer at a node with one
// child) and then rises; set key adds a rise pass. One request at a time; the
// single read port of the slot RAM sets the pace, and a stalled response beat
// holds the next one.
// Reset clears fill count and id presence bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module addressable_min_heap #(
  parameter int HEAP_DEPTH    = amh_pkg::DEF_HEAP_DEPTH,
  parameter int ID_COUNT      = amh_pkg::DEF_ID_COUNT,
  parameter int PAYLOAD_WIDTH = amh_pkg::DEF_PAYLOAD_WIDTH
) (
  input logic clk,
  input logic rst,
  amh_req_if.sink   req,
  amh_rsp_if.source rsp,
  amh_cfg_if.sink   cfg
);
  import amh_pkg::*;

  localparam int AW       = $clog2(HEAP_DEPTH);
  localparam int FW       = $clog2(HEAP_DEPTH + 1);
  localparam int CW       = (FW > CAP_W) ? FW : CAP_W;
  localparam int ID_SLOTS = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int IW       = $clog2(ID_SLOTS);
  localparam int SWD      = ID_W + KEY_W + PAYLOAD_WIDTH;

  state_t state, state_next;

  logic [CAP_W-1:0]         cap;
  logic [FW-1:0]            fill;
  logic [ID_SLOTS-1:0]      present;
  op_t                      op;
  logic [ID_W-1:0]          id_q;
  logic signed [KEY_W-1:0]  key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic                     ins_phase;
  logic [AW-1:0]            tgt;
  logic [AW-1:0]            idx;
  logic [ID_W-1:0]          mid;
  logic signed [KEY_W-1:0]  mkey;
  logic [PAYLOAD_WIDTH-1:0] mpay;
  logic [ID_W-1:0]          xid;
  logic signed [KEY_W-1:0]  xkey;
  logic [PAYLOAD_WIDTH-1:0] xpay;
  logic [SWD-1:0]           cword;
  logic [AW-1:0]            caddr;
  status_t                  pst;
  logic [ID_W-1:0]          pid;
  logic signed [KEY_W-1:0]  pkey;
  logic [PAYLOAD_WIDTH-1:0] ppay;

  logic                     s_we;
  logic [AW-1:0]            s_waddr, s_raddr;
  logic [SWD-1:0]           s_wdata, s_rdata;
  logic                     p_we;
  logic [IW-1:0]            p_waddr, p_raddr;
  logic [AW-1:0]            p_wdata, p_rdata;

  logic [ID_W-1:0]          r_id, c_id;
  logic signed [KEY_W-1:0]  r_key, c_key;
  logic [PAYLOAD_WIDTH-1:0] r_pay;
  logic [AW+1:0]            lc, rc;
  logic                     lc_ok, rc_ok;
  logic [AW-1:0]            parent, last_addr;
  logic [CW-1:0]            limit;
  logic                     id_ok;
  status_t                  dec_status;

  assign r_id   = s_rdata[SWD-1 -: ID_W];
  assign r_key  = s_rdata[PAYLOAD_WIDTH +: KEY_W];
  assign r_pay  = s_rdata[PAYLOAD_WIDTH-1:0];
  assign c_id   = cword[SWD-1 -: ID_W];
  assign c_key  = cword[PAYLOAD_WIDTH +: KEY_W];

  assign lc        = (AW + 2)'({idx, 1'b1});
  assign rc        = lc + (AW + 2)'(1);
  assign lc_ok     = lc < (AW + 2)'(fill);
  assign rc_ok     = rc < (AW + 2)'(fill);
  assign parent    = AW'(idx - AW'(1)) >> 1;
  assign last_addr = AW'(fill - FW'(1));

  assign limit = (CW'(cap) > CW'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : CW'(cap);
  assign id_ok = 32'(id_q) < 32'(ID_COUNT);

  always_comb begin
    dec_status = STS_OK;
    case (op)
      OP_INSERT: begin
        if (CW'(fill) >= limit) dec_status = STS_FULL;
        else if (!id_ok) dec_status = STS_NO_ID;
        else if (present[IW'(id_q)]) dec_status = STS_EXISTS;
      end
      OP_DEL_MIN: begin
        if (fill == '0) dec_status = STS_EMPTY;
      end
      default: begin
        if (!id_ok || !present[IW'(id_q)] || FW'(p_rdata) >= fill) dec_status = STS_NO_ID;
      end
    endcase
  end

  amh_ram #(.WIDTH(SWD), .DEPTH(HEAP_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  amh_ram #(.WIDTH(AW), .DEPTH(ID_SLOTS)) u_pos_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  assign p_raddr   = IW'(req.entry_id);
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (req.valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (dec_status != STS_OK) state_next = ST_FINISH;
        else if (op == OP_INSERT) state_next = ST_RISE_RD;
        else state_next = ST_RD_LAST;
      end
      ST_RD_LAST: state_next = ST_RD_TGT;
      ST_RD_TGT:  state_next = ST_GET_TGT;
      ST_GET_TGT: state_next = ST_SINK_RD;
      ST_SINK_RD: state_next = lc_ok ? ST_SINK_L : ST_RISE_RD;
      ST_SINK_L:  state_next = rc_ok ? ST_SINK_R : ST_SINK_MV;
      ST_SINK_R:  state_next = ST_SINK_MV;
      ST_SINK_MV: state_next = (mkey > c_key) ? ST_SINK_RD : ST_RISE_RD;
      ST_RISE_RD: state_next = (idx == '0) ? ST_PLACE : ST_RISE_MV;
      ST_RISE_MV: state_next = (r_key > mkey) ? ST_RISE_RD : ST_PLACE;
      ST_PLACE: begin
        if (!ins_phase && op == OP_SET_KEY) state_next = ST_RISE_RD;
        else state_next = ST_FINISH;
      end
      ST_FINISH:  if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = idx;
    s_wdata = cword;
    s_raddr = '0;
    p_we    = 1'b0;
    p_waddr = IW'(c_id);
    p_wdata = idx;
    case (state)
      ST_RD_LAST: s_raddr = last_addr;
      ST_RD_TGT:  s_raddr = tgt;
      ST_SINK_RD: s_raddr = AW'(lc);
      ST_SINK_L:  s_raddr = AW'(rc);
      ST_SINK_MV: begin
        if (mkey > c_key) begin
          s_we = 1'b1;
          p_we = 1'b1;
        end
      end
      ST_RISE_RD: s_raddr = parent;
      ST_RISE_MV: begin
        if (r_key > mkey) begin
          s_we    = 1'b1;
          s_wdata = s_rdata;
          p_we    = 1'b1;
          p_waddr = IW'(r_id);
        end
      end
      ST_PLACE: begin
        s_we    = 1'b1;
        s_wdata = {mid, mkey, mpay};
        p_we    = 1'b1;
        p_waddr = IW'(mid);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap       <= CAP_RESET;
      fill      <= '0;
      present   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        cap <= cfg.capacity_limit;
      end
      if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (state == ST_PLACE) begin
        if (ins_phase) begin
          present[IW'(mid)] <= 1'b1;
          fill <= fill + FW'(1);
        end else begin
          present[IW'(xid)] <= 1'b0;
          fill <= fill - FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op    <= op_t'(req.opcode);
        id_q  <= req.entry_id;
        key_q <= req.entry_key;
        pay_q <= req.entry_payload;
      end
      ST_DECODE: begin
        pst  <= dec_status;
        pid  <= '0;
        pkey <= '0;
        ppay <= '0;
        idx  <= AW'(fill);
        mid  <= id_q;
        mkey <= key_q;
        mpay <= pay_q;
        ins_phase <= (op == OP_INSERT);
        tgt  <= (op == OP_DEL_MIN) ? '0 : p_rdata;
      end
      ST_RD_TGT: begin
        mid  <= r_id;
        mkey <= r_key;
        mpay <= r_pay;
      end
      ST_GET_TGT: begin
        xid  <= r_id;
        xkey <= r_key;
        xpay <= r_pay;
        idx  <= tgt;
      end
      ST_SINK_L: begin
        cword <= s_rdata;
        caddr <= AW'(lc);
      end
      ST_SINK_R: begin
        if (c_key > r_key) begin
          cword <= s_rdata;
          caddr <= AW'(rc);
        end
      end
      ST_SINK_MV: if (mkey > c_key) idx <= caddr;
      ST_RISE_MV: if (r_key > mkey) idx <= parent;
      ST_PLACE: begin
        if (!ins_phase && op == OP_SET_KEY) begin
          mid       <= id_q;
          mkey      <= key_q;
          mpay      <= xpay;
          idx       <= AW'(fill - FW'(1));
          ins_phase <= 1'b1;
        end else if (!ins_phase) begin
          pid  <= xid;
          pkey <= xkey;
          ppay <= xpay;
        end
      end
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.status      <= pst;
          rsp.out_id      <= pid;
          rsp.out_key     <= pkey;
          rsp.out_payload <= ppay;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/amh_ram.sv =====
// ----------------------------------------------------------------------------
// amh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
